FILE: design/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, constants and character/automaton helpers for the
// assembly token classifier.
// ----------------------------------------------------------------------------
package atc_pkg;

    // saturation limit of the reported word length
    localparam int MAX_TOKEN_LENGTH = 4095;
    localparam int LEN_W            = $clog2(MAX_TOKEN_LENGTH + 1);

    // result field widths
    localparam int CLASS_W   = 5;
    localparam int OUT_LEN_W = 12;
    localparam int BYTE_W    = 8;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 32;
    localparam int RES_BITS  = CLASS_W + OUT_LEN_W + BYTE_W;

    // pattern automata
    localparam int AU_W     = 4;
    localparam int AU_COUNT = 11;
    localparam int PROG_W   = AU_W * AU_COUNT;
    localparam logic [AU_W-1:0] AU_DEAD = 4'd15;

    localparam int AU_DEC = 0;
    localparam int AU_HEX = 1;
    localparam int AU_FLT = 2;
    localparam int AU_CMT = 3;
    localparam int AU_IDN = 4;
    localparam int AU_DOT = 5;
    localparam int AU_ASG = 6;
    localparam int AU_LBL = 7;
    localparam int AU_FIL = 8;
    localparam int AU_OPT = 9;
    localparam int AU_ADR = 10;

    // token classes
    typedef enum logic [CLASS_W-1:0] {
        CLS_UNKNOWN = 5'd0,
        CLS_DEC     = 5'd1,
        CLS_HEX     = 5'd2,
        CLS_FLOAT   = 5'd3,
        CLS_STRING  = 5'd4,
        CLS_CHAR    = 5'd5,
        CLS_PREPROC = 5'd6,
        CLS_COMMENT = 5'd7,
        CLS_OP      = 5'd8,
        CLS_PUNCT   = 5'd9,
        CLS_IDENT   = 5'd10,
        CLS_ASM_DIR = 5'd11,
        CLS_ASM_CMD = 5'd12,
        CLS_ASSIGN  = 5'd13,
        CLS_LABEL   = 5'd14,
        CLS_FILE    = 5'd15,
        CLS_OPTION  = 5'd16,
        CLS_ADDR    = 5'd17
    } class_t;

    // one result word, class in the lowest bits
    typedef struct packed {
        logic                 last;
        logic [BYTE_W-1:0]    first;
        logic [OUT_LEN_W-1:0] len;
        class_t               cls;
    } result_t;

    // character classes
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7a);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_lower(c) || is_upper(c);
    endfunction

    function automatic logic is_head(input logic [7:0] c);
        return is_lower(c) || is_upper(c) || (c == "_");
    endfunction

    function automatic logic is_wordc(input logic [7:0] c);
        return is_alnum(c) || (c == "_");
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == ";") || (c == ",") || (c == "(") || (c == ")");
    endfunction

    // next state of one pattern automaton for one byte
    function automatic logic [AU_W-1:0] au_advance(input int id,
                                                   input logic [AU_W-1:0] s,
                                                   input logic [7:0] c);
        logic [AU_W-1:0] r;
        r = AU_DEAD;
        if (s != AU_DEAD)
        begin
            case (id)
                AU_DEC: r = is_digit(c) ? 4'd1 : AU_DEAD;
                AU_HEX:
                begin
                    if (s == 4'd0)      r = (c == "0") ? 4'd1 : AU_DEAD;
                    else if (s == 4'd1) r = (c == "x") ? 4'd2 : AU_DEAD;
                    else                r = is_hexd(c) ? 4'd3 : AU_DEAD;
                end
                AU_FLT:
                begin
                    if (s == 4'd0)
                        r = is_digit(c) ? 4'd0 : ((c == ".") ? 4'd1 : AU_DEAD);
                    else
                        r = is_digit(c) ? 4'd2 : AU_DEAD;
                end
                AU_CMT:
                begin
                    if (s == 4'd0)      r = (c == "/") ? 4'd1 : AU_DEAD;
                    else if (s == 4'd1)
                        r = (c == "/") ? 4'd2 : ((c == "*") ? 4'd3 : AU_DEAD);
                    else                r = s;
                end
                AU_IDN:
                begin
                    if (s == 4'd0) r = is_head(c) ? 4'd1 : AU_DEAD;
                    else           r = is_wordc(c) ? 4'd1 : AU_DEAD;
                end
                AU_DOT:
                begin
                    if (s == 4'd0)      r = (c == ".") ? 4'd1 : AU_DEAD;
                    else if (s == 4'd1) r = is_wordc(c) ? 4'd2 : AU_DEAD;
                    else if (s == 4'd2)
                        r = is_wordc(c) ? 4'd2 : ((c == ":") ? 4'd3 : AU_DEAD);
                    else                r = AU_DEAD;
                end
                AU_ASG:
                begin
                    if (s == 4'd0)      r = is_head(c) ? 4'd1 : AU_DEAD;
                    else if (s == 4'd1)
                        r = is_wordc(c) ? 4'd1 : ((c == "=") ? 4'd2 : AU_DEAD);
                    else                r = (c == "=") ? AU_DEAD : 4'd2;
                end
                AU_LBL:
                begin
                    if (s == 4'd0)      r = is_head(c) ? 4'd1 : AU_DEAD;
                    else if (s == 4'd1)
                        r = is_wordc(c) ? 4'd1 :
                            ((c == ":") ? 4'd2 : ((c == ".") ? 4'd3 : AU_DEAD));
                    else if (s == 4'd3)
                        r = is_wordc(c) ? 4'd3 : ((c == ":") ? 4'd4 : AU_DEAD);
                    else                r = AU_DEAD;
                end
                AU_FIL:
                begin
                    if (s == 4'd0)      r = is_head(c) ? 4'd1 : AU_DEAD;
                    else if (s == 4'd1)
                        r = is_wordc(c) ? 4'd1 : ((c == ".") ? 4'd2 : AU_DEAD);
                    else if (s == 4'd2)
                        r = (c == "o") ? 4'd3 : ((c == "a") ? 4'd4 : AU_DEAD);
                    else if (s == 4'd4) r = (c == "s") ? 4'd5 : AU_DEAD;
                    else if (s == 4'd5) r = (c == "m") ? 4'd6 : AU_DEAD;
                    else                r = AU_DEAD;
                end
                AU_OPT:
                begin
                    if (s == 4'd0) r = (c == "-") ? 4'd1 : AU_DEAD;
                    else           r = is_alnum(c) ? 4'd2 : AU_DEAD;
                end
                AU_ADR:
                begin
                    case (s)
                        4'd0: r = (c == "[") ? 4'd1 : AU_DEAD;
                        4'd1: r = (c == "e") ? 4'd2 : AU_DEAD;
                        4'd2: r = (c == "b") ? 4'd3 : AU_DEAD;
                        4'd3: r = (c == "p") ? 4'd4 : AU_DEAD;
                        4'd4: r = ((c == "+") || (c == "-")) ? 4'd5 :
                                  (is_digit(c) ? 4'd6 : AU_DEAD);
                        4'd5: r = is_digit(c) ? 4'd6 : AU_DEAD;
                        4'd6: r = is_digit(c) ? 4'd6 :
                                  ((c == "]") ? 4'd7 : AU_DEAD);
                        default: r = AU_DEAD;
                    endcase
                end
                default: r = AU_DEAD;
            endcase
        end
        return r;
    endfunction

    // first matching class of a finished word
    function automatic class_t word_class(input logic [LEN_W-1:0]  len,
                                          input logic [7:0]        f,
                                          input logic [15:0]       recent,
                                          input logic [PROG_W-1:0] prog);
        logic [7:0]      last;
        logic [7:0]      prev;
        logic            ge2;
        logic            ge4;
        logic [AU_W-1:0] cmt;
        logic [AU_W-1:0] dot;
        logic [AU_W-1:0] lbl;
        logic [AU_W-1:0] fil;
        class_t          r;
        last = recent[7:0];
        prev = recent[15:8];
        ge2  = len >= LEN_W'(2);
        ge4  = len >= LEN_W'(4);
        cmt  = prog[AU_CMT*AU_W +: AU_W];
        dot  = prog[AU_DOT*AU_W +: AU_W];
        lbl  = prog[AU_LBL*AU_W +: AU_W];
        fil  = prog[AU_FIL*AU_W +: AU_W];
        if (prog[AU_DEC*AU_W +: AU_W] == 4'd1)                 r = CLS_DEC;
        else if (prog[AU_HEX*AU_W +: AU_W] == 4'd3)            r = CLS_HEX;
        else if (prog[AU_FLT*AU_W +: AU_W] == 4'd2)            r = CLS_FLOAT;
        else if (ge2 && (f == 8'h22) && (last == 8'h22))       r = CLS_STRING;
        else if (ge2 && (f == 8'h27) && (last == 8'h27))       r = CLS_CHAR;
        else if (f == "#")                                     r = CLS_PREPROC;
        else if (cmt == 4'd2)                                  r = CLS_COMMENT;
        else if ((cmt == 4'd3) && ge4 && (prev == "*") && (last == "/"))
            r = CLS_COMMENT;
        else if ((len == LEN_W'(1)) &&
                 ((f == "+") || (f == "-") || (f == "*") || (f == "/")))
            r = CLS_OP;
        else if (prog[AU_IDN*AU_W +: AU_W] == 4'd1)            r = CLS_IDENT;
        else if (dot == 4'd3)                                  r = CLS_ASM_DIR;
        else if (dot == 4'd2)                                  r = CLS_ASM_CMD;
        else if (prog[AU_ASG*AU_W +: AU_W] == 4'd2)            r = CLS_ASSIGN;
        else if ((lbl == 4'd2) || (lbl == 4'd4))               r = CLS_LABEL;
        else if ((fil == 4'd3) || (fil == 4'd6))               r = CLS_FILE;
        else if (prog[AU_OPT*AU_W +: AU_W] == 4'd2)            r = CLS_OPTION;
        else if (prog[AU_ADR*AU_W +: AU_W] == 4'd7)            r = CLS_ADDR;
        else                                                   r = CLS_UNKNOWN;
        return r;
    endfunction

endpackage

FILE: design/assembly_token_classifier_core.sv
// ----------------------------------------------------------------------------
// assembly_token_classifier_core
// Splits a byte stream into words and emits one class word per token.
// ----------------------------------------------------------------------------
//
//  channel   | direction | tdata                          | tuser | tlast
//  ----------+-----------+--------------------------------+-------+------------
//  s_axis    | in        | text_byte                      | kind  | -
//  m_axis    | out       | token_class, length, first_byte| -     | last_of_run
//
//  One input word per cycle while s_axis_tready is high; the word state
//  and the eleven pattern automata update in the cycle the byte is accepted.
//  Results go to a four-entry output queue; a delimiter after a word pushes
//  two results, first the word and then the delimiter.
//  Input is taken while the queue has room for two results, so a stalled
//  output side holds the input back after at most four queued results.
//  Reset (rst_n low, asynchronous) empties the queue and clears the word.
// ----------------------------------------------------------------------------
module assembly_token_classifier_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] text_byte
    input  logic [atc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] kind
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [4:0] token_class, [16:5] token_length, [24:17] first_byte, rest zero
    output logic [atc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);

    import atc_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // word state
    logic [LEN_W-1:0]  word_len_reg,   word_len_next;
    logic [7:0]        word_first_reg, word_first_next;
    logic [15:0]       recent_reg,     recent_next;
    logic [PROG_W-1:0] prog_reg,       prog_next;

    // output queue
    result_t           fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              in_acc;
    logic              out_pop;
    logic [7:0]        c;
    logic              kind_end;
    logic              space_evt;
    logic              delim_evt;
    logic              flush_evt;
    logic              have_word;
    result_t           word_res;
    result_t           delim_res;
    result_t           push0;
    result_t           push1;
    logic [1:0]        push_cnt;
    result_t           head_res;

    assign c         = s_axis_tdata;
    assign kind_end  = s_axis_tuser[0];
    assign space_evt = !kind_end && is_space(c);
    assign delim_evt = !kind_end && is_delim(c);
    assign flush_evt = kind_end || space_evt || delim_evt;
    assign have_word = (word_len_reg != '0);

    assign s_axis_tready = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    // results for the current byte
    always_comb
    begin
        word_res.last  = !delim_evt;
        word_res.first = word_first_reg;
        word_res.len   = OUT_LEN_W'(word_len_reg);
        word_res.cls   = word_class(word_len_reg, word_first_reg, recent_reg, prog_reg);

        delim_res.last  = 1'b1;
        delim_res.first = c;
        delim_res.len   = OUT_LEN_W'(1);
        delim_res.cls   = CLS_PUNCT;

        push0    = word_res;
        push1    = delim_res;
        push_cnt = 2'd0;
        if (in_acc)
        begin
            if (flush_evt && have_word)
            begin
                push_cnt = delim_evt ? 2'd2 : 2'd1;
            end
            else if (delim_evt)
            begin
                push0    = delim_res;
                push_cnt = 2'd1;
            end
        end
    end

    // word state and automata update
    always_comb
    begin
        word_len_next   = word_len_reg;
        word_first_next = word_first_reg;
        recent_next     = recent_reg;
        prog_next       = prog_reg;
        if (in_acc)
        begin
            if (flush_evt)
            begin
                word_len_next   = '0;
                word_first_next = '0;
                recent_next     = '0;
                prog_next       = '0;
            end
            else
            begin
                if (!have_word)
                    word_first_next = c;
                if (word_len_reg < LEN_W'(MAX_TOKEN_LENGTH))
                    word_len_next = word_len_reg + LEN_W'(1);
                recent_next = {recent_reg[7:0], c};
                for (int i = 0; i < AU_COUNT; i++)
                begin
                    prog_next[i*AU_W +: AU_W] = au_advance(i, prog_reg[i*AU_W +: AU_W], c);
                end
            end
        end
    end

    // queue pointers
    always_comb
    begin
        head_next  = out_pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push_cnt);
        count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(out_pop);
    end

    // control and word state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg   <= '0;
            word_first_reg <= '0;
            recent_reg     <= '0;
            prog_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            word_len_reg   <= word_len_next;
            word_first_reg <= word_first_next;
            recent_reg     <= recent_next;
            prog_reg       <= prog_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_mem[tail_reg] <= push0;
        if (push_cnt == 2'd2)
            fifo_mem[tail_reg + PTR_W'(1)] <= push1;
    end

    // output word
    assign head_res      = fifo_mem[head_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tlast  = head_res.last;
    assign m_axis_tdata  = {(OUT_DATA_W - RES_BITS)'(0), head_res.first, head_res.len,
                            head_res.cls};

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && flush_evt) |=> (word_len_reg == '0))
        else $error("word not cleared after a break");

    a_take_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !flush_evt) |=> (word_len_reg != '0))
        else $error("text byte not added to word");

    a_delim_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && delim_evt) |=> m_axis_tvalid)
        else $error("delimiter produced no result");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> (!push0.last && push1.last && delim_evt))
        else $error("bad last marking on a result pair");

endmodule
